[hw/rtl/pgcm_pkg.sv]
`timescale 1ns / 1ps

package pgcm_pkg;

  // palette and candidate geometry
  localparam int NumColors  = 16;
  localparam int DupIndex   = 5;   // dark magenta, same color as dark red
  localparam int NumDistinct = NumColors - 1;
  localparam int NumPairs   = NumDistinct * (NumDistinct - 1) / 2;
  // one solid cell per distinct color, three mixed cells per unordered pair
  localparam int NumCand    = NumDistinct + 3 * NumPairs;
  localparam int CoverDen   = 10;
  localparam int QuantStep  = 4;
  localparam int MaxDist    = 765;

  typedef logic [3:0] pal_idx_t;
  typedef logic [9:0] dist_t;
  typedef logic [7:0] chan_t;

  typedef enum logic [1:0] {
    GlyphSolid    = 2'd0,
    GlyphThreeQtr = 2'd1,
    GlyphHalf     = 2'd2,
    GlyphQuarter  = 2'd3
  } glyph_e;

  localparam logic [23:0] PALETTE [NumColors] = '{
    24'h000000, 24'h000080, 24'h008000, 24'h008080,
    24'h800000, 24'h800000, 24'h808000, 24'hC0C0C0,
    24'h808080, 24'h0000FF, 24'h00FF00, 24'h00FFFF,
    24'hFF0000, 24'hFF00FF, 24'hFFFF00, 24'hFFFFFF
  };

  localparam int COVER_TENTHS [4] = '{10, 7, 5, 3};

  // fixed candidate of one cell: its fore and back index, glyph kind and blended color
  typedef struct packed {
    pal_idx_t        fore;
    pal_idx_t        back;
    glyph_e          kind;
    logic [2:0][7:0] mix;   // [0] red, [1] green, [2] blue
  } cand_t;

  // running request state that walks down the chain
  typedef struct packed {
    logic [2:0][7:0] tgt;
    dist_t           best_dist;
    pal_idx_t        best_fore;
    pal_idx_t        best_back;
    glyph_e          best_kind;
  } lane_t;

  typedef logic [7:0] quant_lut_t [256];

  function automatic quant_lut_t build_quant_lut();
    quant_lut_t lut;
    for (int v = 0; v < 256; v++) begin
      if (QuantStep == 0) begin
        lut[v] = 8'(v);
      end else begin
        lut[v] = 8'(v - (v % QuantStep));
      end
    end
    return lut;
  endfunction

  localparam quant_lut_t QUANT_LUT = build_quant_lut();

  function automatic cand_t make_cand(int f, int b, glyph_e k);
    cand_t c;
    int    w;
    int    pf;
    int    pb;
    w = COVER_TENTHS[k];
    c.fore = 4'(f);
    c.back = 4'(b);
    c.kind = k;
    for (int ch = 0; ch < 3; ch++) begin
      pf = int'(PALETTE[f][16 - 8 * ch +: 8]);
      pb = int'(PALETTE[b][16 - 8 * ch +: 8]);
      c.mix[ch] = 8'((w * pf + (CoverDen - w) * pb) / CoverDen);
    end
    return c;
  endfunction

  // candidates in scan order; dropped ones always equal an earlier one
  function automatic cand_t cand_at(int idx);
    cand_t c;
    int    n;
    c = '0;
    n = 0;
    for (int f = 0; f < NumColors; f++) begin
      if (f != DupIndex) begin
        if (n == idx) c = make_cand(f, 0, GlyphSolid);
        n++;
        for (int b = f + 1; b < NumColors; b++) begin
          if (b != DupIndex) begin
            for (int k = 1; k < 4; k++) begin
              if (n == idx) c = make_cand(f, b, glyph_e'(k));
              n++;
            end
          end
        end
      end
    end
    return c;
  endfunction

endpackage

[hw/rtl/palette_glyph_color_matcher.sv]
`timescale 1ns / 1ps

// nearest console cell matcher for one rgb pixel per request
// input channel: red_in_i, green_in_i, blue_in_i under in_valid_i / in_ready_o
// output channel: fore_index_o, back_index_o, glyph_kind_o, match_distance_o
//   under out_valid_o / out_ready_i, exactly one result per request, in order
// each channel is floored to a multiple of the quantizer step on entry, then
// the pixel walks a row of cells, one fixed candidate (fg, bg, coverage) per
// cell, each cell keeping the closest L1 candidate seen so far
// candidates that always equal an earlier one in scan order are left out
// (duplicate dark magenta, solid cells past bg 0, mirrored mixes), so the row
// is NumCand = 330 cells long
// a pixel is registered in every cell of the row in turn, then in the output register
// throughput: one pixel per cycle while the row is not stalled, set by the cell row advancing
// reset clears every valid bit; no result is pending after reset
// when the receiver stalls, the output register holds its result; the row
// keeps moving until its last cell holds a result too, then the whole row
// stalls and in_ready_o drops

module palette_glyph_color_matcher
  import pgcm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] red_in_i,
  input  logic [7:0] green_in_i,
  input  logic [7:0] blue_in_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [3:0] fore_index_o,
  output logic [3:0] back_index_o,
  output logic [1:0] glyph_kind_o,
  output logic [9:0] match_distance_o
);

  // lane[i] feeds cell i, lane[NumCand] is the tail of the row
  lane_t lane  [NumCand+1];
  logic  valid [NumCand+1];
  logic  adv;
  logic  take;

  // output register
  logic  out_valid_q, out_valid_d;
  lane_t out_q;

  // head of the row: floored target and an empty best
  always_comb begin
    lane[0].tgt[0]   = QUANT_LUT[red_in_i];
    lane[0].tgt[1]   = QUANT_LUT[green_in_i];
    lane[0].tgt[2]   = QUANT_LUT[blue_in_i];
    lane[0].best_dist = '1;   // above any real distance
    lane[0].best_fore = '0;
    lane[0].best_back = '0;
    lane[0].best_kind = GlyphSolid;
  end
  assign valid[0] = in_valid_i;

  // the row moves unless its tail holds a result the output cannot take
  assign take       = valid[NumCand] && (!out_valid_q || out_ready_i);
  assign adv        = !valid[NumCand] || !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  for (genvar i = 0; i < NumCand; i++) begin : g_cell
    pgcm_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .cand_i  (cand_at(i)),
      .valid_i (valid[i]),
      .lane_i  (lane[i]),
      .valid_o (valid[i+1]),
      .lane_o  (lane[i+1])
    );
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (take) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q <= lane[NumCand];
    end
  end

  assign out_valid_o      = out_valid_q;
  assign fore_index_o     = out_q.best_fore;
  assign back_index_o     = out_q.best_back;
  assign glyph_kind_o     = out_q.best_kind;
  assign match_distance_o = out_q.best_dist;

  a_dist_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> match_distance_o <= 10'(MaxDist))
    else $error("result distance out of range");

  a_accept_behind_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid[NumCand] |-> in_ready_o)
    else $error("row refused a request with an empty tail");

  a_tail_not_lost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid[NumCand] && !take |=> valid[NumCand] && $stable(lane[NumCand]))
    else $error("tail result dropped while the output was busy");

endmodule

[hw/rtl/pgcm_cell.sv]
`timescale 1ns / 1ps

module pgcm_cell
  import pgcm_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  adv_i,
  input  cand_t cand_i,
  input  logic  valid_i,
  input  lane_t lane_i,
  output logic  valid_o,
  output lane_t lane_o
);

  logic  valid_q, valid_d;
  lane_t lane_q, lane_d;
  logic [2:0][7:0] diff;
  dist_t cand_dist;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      diff[ch] = (lane_i.tgt[ch] > cand_i.mix[ch]) ? lane_i.tgt[ch] - cand_i.mix[ch]
                                                   : cand_i.mix[ch] - lane_i.tgt[ch];
    end
    cand_dist = 10'(diff[0]) + 10'(diff[1]) + 10'(diff[2]);
  end

  always_comb begin
    lane_d  = lane_i;
    valid_d = adv_i ? valid_i : valid_q;
    // strictly smaller only, so the earlier candidate keeps a tie
    if (cand_dist < lane_i.best_dist) begin
      lane_d.best_dist = cand_dist;
      lane_d.best_fore = cand_i.fore;
      lane_d.best_back = cand_i.back;
      lane_d.best_kind = cand_i.kind;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      lane_q <= lane_d;
    end
  end

  assign valid_o = valid_q;
  assign lane_o  = lane_q;

  a_best_never_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && valid_i |=> lane_o.best_dist <= $past(lane_i.best_dist))
    else $error("best distance grew in a cell");

  a_target_carried: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && valid_i |=> lane_o.tgt == $past(lane_i.tgt))
    else $error("target color changed inside a cell");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv_i |=> valid_o == $past(valid_o))
    else $error("cell valid moved while the chain was stalled");

endmodule

[bench/palette_glyph_color_matcher_tb.sv]
`timescale 1ns / 1ps

// checks the nearest console cell matcher against its own full 16 x 16 x 4 scan
// of every (fg, bg, coverage) cell, one expected match per accepted request

module palette_glyph_color_matcher_tb;
  import pgcm_pkg::*;

  // no accept on either channel for this many cycles means the block is stuck
  localparam int WatchdogLimit = 4000;
  localparam int NumRandom     = 1230;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
  } pixel_t;

  typedef struct packed {
    pal_idx_t fore;
    pal_idx_t back;
    glyph_e   kind;
    dist_t    distance;
  } cell_match_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] red_in = '0;
  logic [7:0] green_in = '0;
  logic [7:0] blue_in = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [3:0] fore_index;
  logic [3:0] back_index;
  logic [1:0] glyph_kind;
  logic [9:0] match_distance;

  pixel_t      pixel_q [$];   // requests still to be sent
  cell_match_t match_q [$];   // predicted cells, oldest first
  int          mismatch_count = 0;
  int          idle_cycles = 0;
  int          send_gap = 0;
  int          send_quiet = 0;
  int          recv_hold = 0;
  int          recv_quiet = 0;

  wire in_fire  = in_valid && in_ready;
  wire out_fire = out_valid && out_ready;

  always #5 clk_i = ~clk_i;

  palette_glyph_color_matcher u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .red_in_i         (red_in),
    .green_in_i       (green_in),
    .blue_in_i        (blue_in),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .fore_index_o     (fore_index),
    .back_index_o     (back_index),
    .glyph_kind_o     (glyph_kind),
    .match_distance_o (match_distance)
  );

  // full scan of every cell in fg, bg, coverage order; only a strictly
  // closer cell replaces the best, so the first one wins a tie
  function automatic cell_match_t nearest_cell(pixel_t px);
    cell_match_t best;
    int          tgt [3];
    int          best_sum;
    int          w;
    int          fg_c;
    int          bg_c;
    int          mix;
    int          d_sum;
    tgt[0] = int'(px.red);
    tgt[1] = int'(px.green);
    tgt[2] = int'(px.blue);
    // floor each channel to the quantizer step, a zero step leaves it alone
    for (int ch = 0; ch < 3; ch++) begin
      if (QuantStep != 0) tgt[ch] = tgt[ch] - (tgt[ch] % QuantStep);
    end
    best = '0;
    best_sum = 32'h7fff_ffff;
    for (int f = 0; f < NumColors; f++) begin
      for (int b = 0; b < NumColors; b++) begin
        for (int k = 0; k < 4; k++) begin
          w = COVER_TENTHS[k];
          d_sum = 0;
          for (int ch = 0; ch < 3; ch++) begin
            // red sits in the top byte of a palette word
            fg_c = int'(PALETTE[f][16 - 8 * ch +: 8]);
            bg_c = int'(PALETTE[b][16 - 8 * ch +: 8]);
            mix = (w * fg_c + (CoverDen - w) * bg_c) / CoverDen;
            d_sum += (mix > tgt[ch]) ? mix - tgt[ch] : tgt[ch] - mix;
          end
          if (d_sum < best_sum) begin
            best_sum      = d_sum;
            best.fore     = pal_idx_t'(f);
            best.back     = pal_idx_t'(b);
            best.kind     = glyph_e'(k);
            best.distance = dist_t'(d_sum);
          end
        end
      end
    end
    return best;
  endfunction

  // mostly back to back, some short pauses, a few long ones
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  // a channel level within a few steps of a palette level
  function automatic chan_t near_level(int base);
    int v;
    v = base + $urandom_range(0, 40) - 20;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return chan_t'(v);
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch at %0t: %s got %0d, expected %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  task automatic queue_pixel(int red, int green, int blue);
    pixel_q.push_back('{red: chan_t'(red), green: chan_t'(green), blue: chan_t'(blue)});
  endtask

  // request driver: a new pixel goes out once the previous one is taken and
  // its gap has run out; quiet stretches send back to back
  always @(posedge clk_i or negedge rst_ni) begin : send_proc
    pixel_t px;
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        match_q.push_back(nearest_cell('{red: red_in, green: green_in, blue: blue_in}));
      end
      if (send_gap != 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (pixel_q.size() != 0) begin
        px = pixel_q.pop_front();
        red_in   <= px.red;
        green_in <= px.green;
        blue_in  <= px.blue;
        in_valid <= 1'b1;
        if (send_quiet != 0) begin
          send_quiet <= send_quiet - 1;
          send_gap   <= 0;
        end else begin
          send_gap <= idle_len();
          if ($urandom_range(0, 49) == 0) send_quiet <= $urandom_range(50, 300);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result monitor: checks each accepted result against the oldest prediction
  // and throttles out_ready with its own stalls
  always @(posedge clk_i or negedge rst_ni) begin : recv_proc
    cell_match_t want;
    int          hold;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_fire) begin
        if (match_q.size() == 0) begin
          report_mismatch("unexpected result, fore_index", fore_index, 0);
        end else begin
          want = match_q.pop_front();
          if (fore_index != want.fore) report_mismatch("fore_index", fore_index, want.fore);
          if (back_index != want.back) report_mismatch("back_index", back_index, want.back);
          if (glyph_kind != want.kind) report_mismatch("glyph_kind", glyph_kind, want.kind);
          if (match_distance != want.distance) begin
            report_mismatch("match_distance", match_distance, want.distance);
          end
        end
      end
      if (recv_hold != 0) begin
        recv_hold <= recv_hold - 1;
        out_ready <= 1'b0;
      end else if (recv_quiet != 0) begin
        recv_quiet <= recv_quiet - 1;
        out_ready  <= 1'b1;
      end else begin
        hold = idle_len();
        if (hold == 0) begin
          out_ready <= 1'b1;
          if ($urandom_range(0, 199) == 0) recv_quiet <= $urandom_range(50, 400);
        end else begin
          out_ready <= 1'b0;
          recv_hold <= hold - 1;
        end
      end
    end
  end

  // watchdog on cycles with no accept on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_fire || out_fire) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles == WatchdogLimit) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    int pick_a;
    int pick_b;

    // black, white and black after flooring
    queue_pixel(0, 0, 0);
    queue_pixel(255, 255, 255);
    queue_pixel(3, 3, 3);
    // primaries and the bright mixes
    queue_pixel(255, 0, 0);
    queue_pixel(0, 255, 0);
    queue_pixel(0, 0, 255);
    queue_pixel(255, 255, 0);
    queue_pixel(255, 0, 255);
    queue_pixel(0, 255, 255);
    // dark red and dark magenta share one color, the lower index must win
    queue_pixel(128, 0, 0);
    queue_pixel(192, 192, 192);
    queue_pixel(128, 128, 128);
    // odd low bits on each channel
    queue_pixel(254, 1, 127);
    queue_pixel(1, 254, 128);
    queue_pixel(127, 128, 253);
    // halfway points where several cells lie at equal distance
    queue_pixel(64, 64, 64);
    queue_pixel(64, 0, 0);
    queue_pixel(96, 0, 96);
    queue_pixel(178, 178, 0);
    queue_pixel(0, 76, 76);
    queue_pixel(200, 100, 50);

    // random part: plain noise, pixels near one palette color, and pixels
    // near a blend of two palette colors
    for (int n = 0; n < NumRandom; n++) begin
      pick_a = $urandom_range(0, NumColors - 1);
      pick_b = $urandom_range(0, NumColors - 1);
      case ($urandom_range(0, 3))
        0, 1: begin
          queue_pixel($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
        end
        2: begin
          queue_pixel(near_level(PALETTE[pick_a][23:16]), near_level(PALETTE[pick_a][15:8]),
                      near_level(PALETTE[pick_a][7:0]));
        end
        default: begin
          queue_pixel(near_level((PALETTE[pick_a][23:16] + PALETTE[pick_b][23:16]) / 2),
                      near_level((PALETTE[pick_a][15:8] + PALETTE[pick_b][15:8]) / 2),
                      near_level((PALETTE[pick_a][7:0] + PALETTE[pick_b][7:0]) / 2));
        end
      endcase
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // drain: all requests out, all predictions matched, then a wait longer
    // than the pipeline to catch any stray result
    while (pixel_q.size() != 0 || in_valid) @(posedge clk_i);
    while (match_q.size() != 0) @(posedge clk_i);
    repeat (NumCand + 40) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/pgcm_pkg.sv
hw/rtl/pgcm_cell.sv
hw/rtl/palette_glyph_color_matcher.sv
bench/palette_glyph_color_matcher_tb.sv
